[design/rpea_pkg.sv]
`timescale 1ns / 1ps
package rpea_pkg;

	localparam int FRAC_BITS_DEF       = 32;
	localparam int EXP_TABLE_DEPTH_DEF = 256;
	localparam int DATA_W              = 64;
	localparam int FIELD_W             = 49;
	localparam int FLOW_W              = 40;
	localparam int CFG_INDEX_W         = 2;
	localparam int SERIES_BITS         = 50;
	localparam int SERIES_TERMS        = 20;
	localparam int EXP_INT_LIMIT       = 48;
	localparam int MUL_DIGIT           = 16;
	localparam int MUL_STEPS           = DATA_W / MUL_DIGIT;

	localparam logic [DATA_W-1:0] SAT_MAG = {1'b0, {(DATA_W-1){1'b1}}};

	localparam logic [CFG_INDEX_W-1:0] REG_FLOW_PARAM  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PLAIN_DENOM = CFG_INDEX_W'(1);

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_ZERO, OP_DD, OP_XS, OP_ESET, OP_TAB0, OP_TAB1,
		OP_INTERP, OP_EPOW, OP_SD, OP_TP, OP_JE, OP_TT, OP_FAC, OP_JF,
		OP_DIVT, OP_DIVJ, OP_CONTRIB, OP_DBL, OP_ACC, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic start;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic d_zero;
		logic plain;
		logic exp_big;
		logic n_zero;
		logic taylor;
		logic last;
		logic emit_ok;
	} stat_t;

	function automatic logic [DATA_W-1:0] abs64(logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

endpackage

[design/regularized_pair_energy_accumulator.sv]
`timescale 1ns / 1ps
// Channel  Handshake                Payload
// in       in_valid / in_stall      e_core_first .. exchange_integral, same_pair, last
// out      out_valid / out_stall    energy, zero_denominator (only for last items)
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data (0: flow_param, 1: plain_denominator)
//
// One request at a time; in_stall is high from acceptance until the item is folded in
// and, for a last item, emitted. Multiplies run on one 64x16 unit, divides on one
// restoring divider. Regularized items take n exp power steps (n = integer part of
// s*D*D, below 48), none once exp underflows. A last item waits while a previous
// result is still held. Reset clears the sum and flags; flow_param returns to 1.0.
// The exp table is constant.
module regularized_pair_energy_accumulator #(
	parameter int FRAC_BITS       = rpea_pkg::FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = rpea_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [rpea_pkg::FIELD_W-1:0]  e_core_first,
	input  logic signed [rpea_pkg::FIELD_W-1:0]  e_core_second,
	input  logic signed [rpea_pkg::FIELD_W-1:0]  e_virt_first,
	input  logic signed [rpea_pkg::FIELD_W-1:0]  e_virt_second,
	input  logic signed [rpea_pkg::FIELD_W-1:0]  direct_integral,
	input  logic signed [rpea_pkg::FIELD_W-1:0]  exchange_integral,
	input  logic                                 same_pair,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rpea_pkg::DATA_W-1:0]   energy,
	output logic                                 zero_denominator,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rpea_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rpea_pkg::FLOW_W-1:0]          cfg_data
);
	import rpea_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  busy;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;

	rpea_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	rpea_dp #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.e_core_first(e_core_first), .e_core_second(e_core_second),
		.e_virt_first(e_virt_first), .e_virt_second(e_virt_second),
		.direct_integral(direct_integral), .exchange_integral(exchange_integral),
		.same_pair(same_pair), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.energy(energy), .zero_denominator(zero_denominator)
	);

endmodule

[design/rpea_mul.sv]
`timescale 1ns / 1ps
module rpea_mul #(
	parameter int FRAC_BITS = rpea_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [rpea_pkg::DATA_W-1:0]  a,
	input  logic signed [rpea_pkg::DATA_W-1:0]  b,
	output logic                                done,
	output logic signed [rpea_pkg::DATA_W-1:0]  p
);
	import rpea_pkg::*;

	localparam int CW = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

	logic [DATA_W-1:0]           am_q, bm_q;
	logic                        neg_q, busy_q, fin_q, done_q;
	logic [CW-1:0]               cnt_q;
	logic [2*DATA_W-1:0]         acc_q;
	logic [DATA_W+MUL_DIGIT-1:0] pp;
	logic [2*DATA_W-1:0]         shifted;
	logic [DATA_W-1:0]           mag;
	logic signed [DATA_W-1:0]    p_q;

	assign pp      = am_q * bm_q[MUL_DIGIT-1:0];
	assign shifted = acc_q >> FRAC_BITS;
	// saturate once anything lands at or above bit 63 after the shift
	assign mag     = (|shifted[2*DATA_W-1:DATA_W-1]) ? SAT_MAG : shifted[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= !start && busy_q && (cnt_q == CW'(MUL_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= abs64(a);
			bm_q  <= abs64(b);
			neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + ((2*DATA_W)'(pp) << (MUL_DIGIT * int'(cnt_q)));
			bm_q  <= bm_q >> MUL_DIGIT;
		end
		if (fin_q)
			p_q <= neg_q ? -$signed(mag) : $signed(mag);
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

[design/rpea_div.sv]
`timescale 1ns / 1ps
module rpea_div #(
	parameter int FRAC_BITS = rpea_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [rpea_pkg::DATA_W-1:0]  a,
	input  logic signed [rpea_pkg::DATA_W-1:0]  b,
	output logic                                done,
	output logic signed [rpea_pkg::DATA_W-1:0]  q
);
	import rpea_pkg::*;

	localparam int N  = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]             dvd_q, quo_q;
	logic [DATA_W-1:0]        rem_q, ub_q, mag;
	logic                     neg_q, busy_q, fin_q, done_q;
	logic [CW-1:0]            cnt_q;
	logic [DATA_W:0]          r2, diff;
	logic                     ge;
	logic signed [DATA_W-1:0] q_q;

	// restoring division of (|a| << FRAC_BITS) by |b|, one quotient bit a cycle
	assign r2   = {rem_q, dvd_q[N-1]};
	assign diff = r2 - {1'b0, ub_q};
	assign ge   = (r2 >= {1'b0, ub_q});
	assign mag  = (|quo_q[N-1:DATA_W-1]) ? SAT_MAG : {1'b0, quo_q[DATA_W-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= !start && busy_q && (cnt_q == CW'(N - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(N - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {abs64(a), {FRAC_BITS{1'b0}}};
			ub_q  <= abs64(b);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : r2[DATA_W-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[N-2:0], ge};
		end
		if (fin_q)
			q_q <= neg_q ? -$signed(mag) : $signed(mag);
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

[design/rpea_dp.sv]
`timescale 1ns / 1ps
module rpea_dp #(
	parameter int FRAC_BITS       = rpea_pkg::FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = rpea_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rpea_pkg::cmd_t                         cmd,
	output rpea_pkg::stat_t                        stat,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [rpea_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [rpea_pkg::FLOW_W-1:0]            cfg_data,
	input  logic signed [rpea_pkg::FIELD_W-1:0]    e_core_first,
	input  logic signed [rpea_pkg::FIELD_W-1:0]    e_core_second,
	input  logic signed [rpea_pkg::FIELD_W-1:0]    e_virt_first,
	input  logic signed [rpea_pkg::FIELD_W-1:0]    e_virt_second,
	input  logic signed [rpea_pkg::FIELD_W-1:0]    direct_integral,
	input  logic signed [rpea_pkg::FIELD_W-1:0]    exchange_integral,
	input  logic                                   same_pair,
	input  logic                                   last,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rpea_pkg::DATA_W-1:0]     energy,
	output logic                                   zero_denominator
);
	import rpea_pkg::*;

	localparam int TW    = FRAC_BITS + 1;
	localparam int IDXW  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int NW    = $clog2(EXP_INT_LIMIT);
	localparam int PW    = FRAC_BITS + IDXW;
	localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(1) <<< FRAC_BITS;
	localparam logic [DATA_W-1:0]        SMALL_X =
		((DATA_W'(1) << FRAC_BITS) + DATA_W'(999999)) / DATA_W'(1000000);
	localparam logic signed [DATA_W-1:0] S_MAX = $signed(SAT_MAG);
	localparam logic signed [DATA_W-1:0] S_MIN = $signed(~SAT_MAG);

	typedef logic [EXP_TABLE_DEPTH:0][TW-1:0] tab_t;

	// exp(-k/DEPTH) from an integer series with SERIES_BITS fraction bits, rounded
	function automatic tab_t build_tab();
		tab_t                r;
		logic [63:0]         t, term;
		logic [127:0]        pr;
		logic signed [63:0]  sum;
		for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
			t    = (64'(k) << SERIES_BITS) / 64'(EXP_TABLE_DEPTH);
			term = 64'd1 << SERIES_BITS;
			sum  = $signed(term);
			for (int n = 1; n <= SERIES_TERMS; n++) begin
				pr   = 128'(term) * 128'(t);
				term = 64'(pr >> SERIES_BITS) / 64'(n);
				if (n % 2 == 1)
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
			end
			r[k] = TW'((64'(sum) + (64'd1 << (SERIES_BITS - FRAC_BITS - 1)))
				>> (SERIES_BITS - FRAC_BITS));
		end
		return r;
	endfunction

	localparam tab_t EXP_TAB = build_tab();

	function automatic logic signed [DATA_W-1:0] sat_add(
		logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
		logic signed [DATA_W:0] s;
		s = (DATA_W+1)'(x) + (DATA_W+1)'(y);
		if (s > (DATA_W+1)'(S_MAX))
			return S_MAX;
		if (s < (DATA_W+1)'(S_MIN))
			return S_MIN;
		return DATA_W'(s);
	endfunction

	logic signed [DATA_W-1:0] s_q;
	logic                     plain_q;
	logic signed [DATA_W-1:0] d_q, jv_q, w_q, t_q, x_q, u_q, term_q, e_q, acc_q;
	logic                     same_q, last_q, zero_q;
	logic [NW-1:0]            n_q;
	logic [IDXW-1:0]          idx_q;
	logic [FRAC_BITS-1:0]     fr_q;
	logic [TW-1:0]            tab0_q, diff_q;
	logic                     out_valid_q, zero_out_q;
	logic signed [DATA_W-1:0] energy_q;

	logic signed [DATA_W-1:0] mul_a, mul_b, mul_p, div_q, ope, taylor_p;
	logic                     mul_done, div_done, mul_start, div_start;
	logic                     is_div, exp_big, emit_ok;
	logic [PW-1:0]            pos;

	assign ope      = ONE_Q + e_q;
	// below the series threshold x*x and x*x*x vanish at this precision
	assign taylor_p = ONE_Q - (x_q >>> 1);
	assign exp_big  = (x_q >> FRAC_BITS) >= DATA_W'(EXP_INT_LIMIT);
	assign pos      = PW'(x_q[FRAC_BITS-1:0]) * PW'(EXP_TABLE_DEPTH);
	assign emit_ok  = !out_valid_q || !out_stall;
	assign is_div   = (cmd.op == OP_DIVT) || (cmd.op == OP_DIVJ);
	assign mul_start = cmd.start && !is_div;
	assign div_start = cmd.start && is_div;

	always_comb begin
		mul_a = term_q;
		mul_b = w_q;
		case (cmd.op)
			OP_DD:     begin mul_a = d_q;   mul_b = d_q; end
			OP_XS:     begin mul_a = t_q;   mul_b = s_q; end
			OP_INTERP: begin mul_a = DATA_W'(diff_q); mul_b = DATA_W'(fr_q); end
			OP_EPOW:   begin mul_a = e_q;   mul_b = DATA_W'(EXP_TAB[EXP_TABLE_DEPTH]); end
			OP_SD:     begin mul_a = s_q;   mul_b = d_q; end
			OP_TP:     begin mul_a = t_q;   mul_b = taylor_p; end
			OP_JE:     begin mul_a = jv_q;  mul_b = ope; end
			OP_TT:     begin mul_a = u_q;   mul_b = t_q; end
			OP_FAC:    begin mul_a = ope;   mul_b = ONE_Q - e_q; end
			OP_JF:     begin mul_a = jv_q;  mul_b = t_q; end
			default:   begin mul_a = term_q; mul_b = w_q; end
		endcase
	end

	rpea_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	rpea_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.a((cmd.op == OP_DIVJ) ? jv_q : t_q), .b(d_q), .done(div_done), .q(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q         <= ONE_Q;
			plain_q     <= 1'b0;
			acc_q       <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FLOW_PARAM:  s_q     <= DATA_W'(cfg_data);
					REG_PLAIN_DENOM: plain_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && (cmd.op != OP_EMIT))
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_ZERO: zero_q <= 1'b1;
				OP_ACC:  acc_q  <= sat_add(acc_q, u_q);
				OP_EMIT: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						acc_q       <= '0;
						zero_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				d_q <= DATA_W'(e_core_first) + DATA_W'(e_core_second)
					- DATA_W'(e_virt_first) - DATA_W'(e_virt_second);
				jv_q   <= DATA_W'(direct_integral);
				w_q    <= (DATA_W'(direct_integral) <<< 1) - DATA_W'(exchange_integral);
				same_q <= same_pair;
				last_q <= last;
			end
			OP_ZERO: term_q <= '0;
			OP_ESET: begin
				if (exp_big)
					e_q <= '0;
				n_q   <= x_q[FRAC_BITS +: NW];
				idx_q <= pos[PW-1:FRAC_BITS];
				fr_q  <= pos[FRAC_BITS-1:0];
			end
			OP_TAB0: tab0_q <= EXP_TAB[idx_q];
			OP_TAB1: diff_q <= tab0_q - EXP_TAB[IDXW'(idx_q + 1'b1)];
			OP_DBL:  if (!same_q) u_q <= sat_add(u_q, u_q);
			OP_EMIT: begin
				if (emit_ok) begin
					energy_q   <= acc_q;
					zero_out_q <= zero_q;
				end
			end
			default: ;
		endcase
		if (mul_done) begin
			case (cmd.op)
				OP_DD, OP_SD, OP_TP, OP_FAC, OP_JF: t_q <= mul_p;
				OP_XS:      x_q    <= mul_p;
				OP_INTERP:  e_q    <= DATA_W'(tab0_q) - mul_p;
				OP_EPOW: begin
					e_q <= mul_p;
					n_q <= n_q - 1'b1;
				end
				OP_JE, OP_CONTRIB: u_q <= mul_p;
				OP_TT:      term_q <= mul_p;
				default: ;
			endcase
		end
		if (div_done)
			term_q <= div_q;
	end

	assign stat.done    = mul_done || div_done;
	assign stat.d_zero  = (d_q == '0);
	assign stat.plain   = plain_q;
	assign stat.exp_big = exp_big;
	assign stat.n_zero  = (n_q == '0);
	assign stat.taylor  = (x_q < SMALL_X);
	assign stat.last    = last_q;
	assign stat.emit_ok = emit_ok;

	assign out_valid        = out_valid_q;
	assign energy           = energy_q;
	assign zero_denominator = zero_out_q;

endmodule

[design/rpea_ctrl.sv]
`timescale 1ns / 1ps
module rpea_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rpea_pkg::stat_t  stat,
	output rpea_pkg::cmd_t   cmd,
	output logic             busy
);
	import rpea_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_ZERO, S_DD, S_XS, S_ESET, S_TAB0, S_TAB1, S_INTERP,
		S_ECHK, S_EPOW, S_BR, S_SD, S_TP, S_JE, S_TT, S_FAC, S_JF, S_DIVT,
		S_DIVJ, S_CONTRIB, S_DBL, S_ACC, S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   start_q;
	op_t    op;

	function automatic logic uses_unit(state_t s);
		case (s)
			S_DD, S_XS, S_INTERP, S_EPOW, S_SD, S_TP, S_JE, S_TT, S_FAC, S_JF,
			S_DIVT, S_DIVJ, S_CONTRIB: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_CHECK;
			S_CHECK:   state_d = stat.d_zero ? S_ZERO : (stat.plain ? S_DIVJ : S_DD);
			S_ZERO:    state_d = S_CONTRIB;
			S_DD:      if (stat.done) state_d = S_XS;
			S_XS:      if (stat.done) state_d = S_ESET;
			S_ESET:    state_d = stat.exp_big ? S_BR : S_TAB0;
			S_TAB0:    state_d = S_TAB1;
			S_TAB1:    state_d = S_INTERP;
			S_INTERP:  if (stat.done) state_d = S_ECHK;
			S_ECHK:    state_d = stat.n_zero ? S_BR : S_EPOW;
			S_EPOW:    if (stat.done) state_d = S_ECHK;
			S_BR:      state_d = stat.taylor ? S_SD : S_FAC;
			S_SD:      if (stat.done) state_d = S_TP;
			S_TP:      if (stat.done) state_d = S_JE;
			S_JE:      if (stat.done) state_d = S_TT;
			S_TT:      if (stat.done) state_d = S_CONTRIB;
			S_FAC:     if (stat.done) state_d = S_JF;
			S_JF:      if (stat.done) state_d = S_DIVT;
			S_DIVT:    if (stat.done) state_d = S_CONTRIB;
			S_DIVJ:    if (stat.done) state_d = S_CONTRIB;
			S_CONTRIB: if (stat.done) state_d = S_DBL;
			S_DBL:     state_d = S_ACC;
			S_ACC:     state_d = stat.last ? S_EMIT : S_IDLE;
			S_EMIT:    if (stat.emit_ok) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE:    op = in_valid ? OP_LOAD : OP_NONE;
			S_ZERO:    op = OP_ZERO;
			S_DD:      op = OP_DD;
			S_XS:      op = OP_XS;
			S_ESET:    op = OP_ESET;
			S_TAB0:    op = OP_TAB0;
			S_TAB1:    op = OP_TAB1;
			S_INTERP:  op = OP_INTERP;
			S_EPOW:    op = OP_EPOW;
			S_SD:      op = OP_SD;
			S_TP:      op = OP_TP;
			S_JE:      op = OP_JE;
			S_TT:      op = OP_TT;
			S_FAC:     op = OP_FAC;
			S_JF:      op = OP_JF;
			S_DIVT:    op = OP_DIVT;
			S_DIVJ:    op = OP_DIVJ;
			S_CONTRIB: op = OP_CONTRIB;
			S_DBL:     op = OP_DBL;
			S_ACC:     op = OP_ACC;
			S_EMIT:    op = OP_EMIT;
			default:   op = OP_NONE;
		endcase
	end

	// start pulses in the first cycle of every state that runs the multiplier or divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= uses_unit(state_d) && (state_d != state_q);
		end
	end

	assign cmd.op    = op;
	assign cmd.start = start_q;
	assign busy      = (state_q != S_IDLE);

endmodule
